>>> rtl/core/grrl_pkg.sv
// Shared constants and types for the glyph range record lookup core.
// Used by the top level; no dependencies.
package grrl_pkg;

    localparam int MAX_RECORDS = 4096;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int GLYPH_W = 16;
    localparam int WORD_W  = 32;
    localparam int RANGE_W = 2 * GLYPH_W;
    localparam int LOC_W   = 2 * WORD_W;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FOUND  = 2'd1,
        ST_MISS   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    localparam logic [0:0] CFG_LIST_BASE  = 1'b0;
    localparam logic [0:0] CFG_TABLE_SIZE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SRCH   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

>>> rtl/core/grrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/glyph_range_record_lookup_core.sv
// Top level of the glyph range record lookup core: sequencer, bisection and load checks.
// Depends on grrl_pkg and grrl_ram.
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   action, range, offset, length, glyph
// output    out        o_out_valid / i_out_stall status, index, offset, length, count
// config    in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// Clear, load and unused actions pass from accept straight to the finish state.
// A lookup runs k bisection steps (13 at most for 4096 records) before its finish state,
// with one read of the range RAM per step through its single read port.
// Reset empties the table by clearing the record count; the RAMs are not cleared.
// A stalled result holds the sequencer in its finish state; the input stalls until idle.
module glyph_range_record_lookup_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [15:0]                 i_range_first,
    input  logic [15:0]                 i_range_last,
    input  logic [31:0]                 i_doc_offset_in,
    input  logic [31:0]                 i_doc_length_in,
    input  logic [15:0]                 i_glyph_id,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [grrl_pkg::IDX_W-1:0]  o_record_index,
    output logic [31:0]                 o_doc_offset_out,
    output logic [31:0]                 o_doc_length_out,
    output logic [grrl_pkg::CNT_W-1:0]  o_record_count,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_wdata
);

    import grrl_pkg::*;

    t_state               r_state, n_state;
    t_action              r_action;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_mid, n_mid;
    logic [GLYPH_W-1:0]   r_first, r_last, r_glyph;
    logic [WORD_W-1:0]    r_off, r_len;
    logic [WORD_W:0]      r_sum;
    logic [WORD_W-1:0]    r_list_base, r_table_size;

    logic                 r_out_valid;
    t_status              r_status;
    logic [IDX_W-1:0]     r_index;
    logic [WORD_W-1:0]    r_off_out, r_len_out;
    logic [CNT_W-1:0]     r_count_out;

    logic                 in_acc, out_free, fin_go;
    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [RANGE_W-1:0]   range_rdata;
    logic [LOC_W-1:0]     loc_rdata;
    logic [CNT_W-1:0]     half;
    logic                 go_right, load_ok, hit;
    logic [WORD_W+1:0]    end_sum;

    t_status              res_status;
    logic [IDX_W-1:0]     res_index;
    logic [WORD_W-1:0]    res_off, res_len;
    logic [CNT_W-1:0]     res_count;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fin_go   = (r_state == S_FINISH) && out_free;

    assign half     = r_n >> 1;
    assign go_right = range_rdata[RANGE_W-1:GLYPH_W] < r_glyph;
    assign end_sum  = (WORD_W+2)'(r_sum) + (WORD_W+2)'(r_list_base);
    assign load_ok  = (r_first <= r_last) && (r_len != '0)
                   && (r_count < CNT_W'(MAX_RECORDS))
                   && (end_sum <= (WORD_W+2)'(r_table_size));
    assign hit      = (r_lo < r_count) && (range_rdata[GLYPH_W-1:0] <= r_glyph);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_n     = r_n;
        n_mid   = r_mid;
        rd_en   = 1'b0;
        rd_addr = r_mid[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_FINISH;
                    if (t_action'(i_action) == ACT_LOOKUP) begin
                        n_lo = '0;
                        n_n  = r_count;
                        if (r_count != '0) begin
                            n_mid   = r_count >> 1;
                            rd_en   = 1'b1;
                            rd_addr = n_mid[IDX_W-1:0];
                            n_state = S_SRCH;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (go_right) begin
                    n_lo = r_mid + CNT_W'(1);
                    n_n  = r_n - half - CNT_W'(1);
                end else begin
                    n_n  = half;
                end
                rd_en = 1'b1;
                if (n_n != '0) begin
                    n_mid   = n_lo + (n_n >> 1);
                    rd_addr = n_mid[IDX_W-1:0];
                end else begin
                    rd_addr = n_lo[IDX_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res_status = ST_OK;
        res_index  = '0;
        res_off    = '0;
        res_len    = '0;
        res_count  = r_count;
        wr_en      = 1'b0;
        unique case (r_action)
            ACT_CLEAR: begin
                res_count = '0;
            end
            ACT_LOAD: begin
                if (load_ok) begin
                    wr_en     = fin_go;
                    res_count = r_count + CNT_W'(1);
                end else begin
                    res_status = ST_REJECT;
                end
            end
            ACT_LOOKUP: begin
                if (hit) begin
                    res_status = ST_FOUND;
                    res_index  = r_lo[IDX_W-1:0];
                    res_off    = loc_rdata[WORD_W-1:0];
                    res_len    = loc_rdata[LOC_W-1:WORD_W];
                end else begin
                    res_status = ST_MISS;
                end
            end
            ACT_NONE: begin
                res_status = ST_OK;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_list_base  <= '0;
            r_table_size <= '0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_n     <= n_n;
            r_mid   <= n_mid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LIST_BASE) begin
                    r_list_base <= i_cfg_wdata;
                end else if (i_cfg_index == CFG_TABLE_SIZE) begin
                    r_table_size <= i_cfg_wdata;
                end
            end
            if (in_acc) begin
                r_action <= t_action'(i_action);
                r_first  <= i_range_first;
                r_last   <= i_range_last;
                r_off    <= i_doc_offset_in;
                r_len    <= i_doc_length_in;
                r_glyph  <= i_glyph_id;
                r_sum    <= (WORD_W+1)'(i_doc_offset_in) + (WORD_W+1)'(i_doc_length_in);
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
                r_status    <= res_status;
                r_index     <= res_index;
                r_off_out   <= res_off;
                r_len_out   <= res_len;
                r_count_out <= res_count;
                r_count     <= res_count;
            end
        end
    end

    grrl_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (MAX_RECORDS)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_last, r_first}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (range_rdata)
    );

    grrl_ram #(
        .WIDTH (LOC_W),
        .DEPTH (MAX_RECORDS)
    ) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_len, r_off}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (loc_rdata)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_record_index   = r_index;
    assign o_doc_offset_out = r_off_out;
    assign o_doc_length_out = r_len_out;
    assign o_record_count   = r_count_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |->
            (r_n != '0) && ((r_lo + r_n) <= r_count) && (r_mid < r_count))
        else $error("bisection window left the stored records");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken again before the item finished");

    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FOUND)) |->
            (CNT_W'(r_index) < r_count_out))
        else $error("found index beyond stored records");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CNT_W'(MAX_RECORDS)))
        else $error("record write into a full table");

endmodule
